### sv/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg: shared types and constants for the planar pose compose unit
// Word formats, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package ppc_pkg;

	// Stage count limit of the arctangent table
	localparam int MAX_STAGES = 24;

	// Internal widths: rotator vector Q2.30 plus guard, angle Q3.29 plus guard
	localparam int ROT_W  = 34;
	localparam int Z_W    = 33;
	localparam int PROD_W = 66;
	localparam int SUM_W  = 67;
	localparam int SH_W   = 37;

	localparam logic signed [Z_W-1:0]   HALF_PI_Q29  = 33'sd843314857;
	localparam logic signed [Z_W-1:0]   PI_Q29       = 33'sd1686629713;
	localparam logic signed [ROT_W-1:0] CORDIC_K_Q30 = 34'sd652032874;
	localparam logic signed [17:0]      PI_Q13       = 18'sd25736;
	localparam logic signed [17:0]      TWO_PI_Q13   = 18'sd51472;
	localparam logic signed [15:0]      PI_HEAD      = 16'sd25736;
	localparam logic signed [SUM_W-1:0] ROUND_HALF   = 67'sd536870912;

	// Input word
	typedef struct packed {
		logic signed [31:0] ref_x;
		logic signed [31:0] ref_y;
		logic signed [15:0] ref_heading;
		logic signed [31:0] delta_x;
		logic signed [31:0] delta_y;
		logic signed [15:0] delta_heading;
	} pose_in_t;

	// Output word
	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [15:0] pose_heading;
	} pose_out_t;

	// Rotator state of one stage
	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [Z_W-1:0]   z;
		logic                    flip;
	} rot_t;

	// Operands that ride along with the rotator
	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [15:0] heading;
	} carry_t;

	// atan(2^-i) in Q3.29, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_q29(input int unsigned idx);
		logic signed [Z_W-1:0] r;
		case (idx)
			0:  r = 33'sd421657428;
			1:  r = 33'sd248918915;
			2:  r = 33'sd131521918;
			3:  r = 33'sd66762579;
			4:  r = 33'sd33510843;
			5:  r = 33'sd16771758;
			6:  r = 33'sd8387925;
			7:  r = 33'sd4194219;
			8:  r = 33'sd2097141;
			9:  r = 33'sd1048575;
			10: r = 33'sd524288;
			11: r = 33'sd262144;
			12: r = 33'sd131072;
			13: r = 33'sd65536;
			14: r = 33'sd32768;
			15: r = 33'sd16384;
			16: r = 33'sd8192;
			17: r = 33'sd4096;
			18: r = 33'sd2048;
			19: r = 33'sd1024;
			20: r = 33'sd512;
			21: r = 33'sd256;
			22: r = 33'sd128;
			23: r = 33'sd64;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### sv/planar_pose_compose_unit.sv
// ----------------------------------------------------------------------------
// planar_pose_compose_unit: SE(2) pose composition
// Pipeline: a front stage, the CORDIC stages, then multiply, sum and output
//   stages (CORDIC stage count capped at 24); one CORDIC iteration per CORDIC stage.
// Throughput: one word per cycle; each stage stalls only when full and blocked,
//   so empty stages fill while the output waits.
// Reset: arst_n clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module planar_pose_compose_unit #(
	parameter int ROTATION_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ppc_pkg::pose_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ppc_pkg::pose_out_t out_data
);
	import ppc_pkg::*;

	localparam int NS     = (ROTATION_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATION_STAGES;
	localparam int MUL_ST = NS + 1;
	localparam int SUM_ST = NS + 2;
	localparam int OUT_ST = NS + 3;
	localparam int N_ST   = NS + 4;

	logic [N_ST-1:0] v_s;
	logic [N_ST:0]   rdy;
	logic [N_ST-1:0] v_in;

	rot_t   rot_s [NS+1];
	carry_t car_s [MUL_ST+1];

	logic signed [PROD_W-1:0] cdx_s, sdy_s, sdx_s, cdy_s;
	logic signed [SH_W-1:0]   px_sh_s, py_sh_s;
	logic signed [31:0]       rx_s, ry_s;
	logic signed [15:0]       hd_s;
	pose_out_t                out_s;

	// Per-stage ready: a stage loads when empty or when the next one moves
	assign rdy[N_ST] = out_ready;
	for (genvar k = 0; k < N_ST; k++) begin : g_rdy
		assign rdy[k] = !v_s[k] || rdy[k+1];
	end

	assign v_in     = {v_s[N_ST-2:0], in_valid};
	assign in_ready = rdy[0];

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 0; k < N_ST; k++) begin
				if (rdy[k]) begin
					v_s[k] <= v_in[k];
				end
			end
		end
	end

	// Front stage: quadrant fold of the angle and heading sum with one wrap
	logic signed [Z_W-1:0] z_in;
	logic signed [17:0]    h_sum;
	logic signed [17:0]    h_wrap1;
	logic signed [17:0]    h_wrap2;
	rot_t                  rot_in;
	carry_t                car_in;

	always_comb begin
		z_in = $signed({in_data.ref_heading[15], in_data.ref_heading, 16'h0000});
		rot_in.x = CORDIC_K_Q30;
		rot_in.y = '0;
		if (z_in > HALF_PI_Q29) begin
			rot_in.z    = z_in - PI_Q29;
			rot_in.flip = 1'b1;
		end else if (z_in < -HALF_PI_Q29) begin
			rot_in.z    = z_in + PI_Q29;
			rot_in.flip = 1'b1;
		end else begin
			rot_in.z    = z_in;
			rot_in.flip = 1'b0;
		end

		h_sum = 18'(in_data.ref_heading) + 18'(in_data.delta_heading);
		h_wrap1 = (h_sum > PI_Q13) ? h_sum - TWO_PI_Q13 : h_sum;
		h_wrap2 = (h_wrap1 < -PI_Q13) ? h_wrap1 + TWO_PI_Q13 : h_wrap1;

		car_in.rx      = in_data.ref_x;
		car_in.ry      = in_data.ref_y;
		car_in.dx      = in_data.delta_x;
		car_in.dy      = in_data.delta_y;
		car_in.heading = h_wrap2[15:0];
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			rot_s[0] <= rot_in;
			car_s[0] <= car_in;
		end
	end

	// CORDIC iterations, one per stage, turning toward zero residual angle
	for (genvar gi = 0; gi < NS; gi++) begin : g_rot
		rot_t                  nxt;
		logic signed [ROT_W-1:0] xs;
		logic signed [ROT_W-1:0] ys;

		always_comb begin
			xs = rot_s[gi].x >>> gi;
			ys = rot_s[gi].y >>> gi;
			nxt.flip = rot_s[gi].flip;
			if (!rot_s[gi].z[Z_W-1]) begin
				nxt.x = rot_s[gi].x - ys;
				nxt.y = rot_s[gi].y + xs;
				nxt.z = rot_s[gi].z - atan_q29(gi);
			end else begin
				nxt.x = rot_s[gi].x + ys;
				nxt.y = rot_s[gi].y - xs;
				nxt.z = rot_s[gi].z + atan_q29(gi);
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[gi+1]) begin
				rot_s[gi+1] <= nxt;
				car_s[gi+1] <= car_s[gi];
			end
		end
	end

	// Multiply stage: undo the quadrant fold, then four products
	logic signed [ROT_W-1:0] cos_v;
	logic signed [ROT_W-1:0] sin_v;

	always_comb begin
		cos_v = rot_s[NS].flip ? -rot_s[NS].x : rot_s[NS].x;
		sin_v = rot_s[NS].flip ? -rot_s[NS].y : rot_s[NS].y;
	end

	always_ff @(posedge clk) begin
		if (rdy[MUL_ST]) begin
			cdx_s         <= cos_v * car_s[NS].dx;
			sdy_s         <= sin_v * car_s[NS].dy;
			sdx_s         <= sin_v * car_s[NS].dx;
			cdy_s         <= cos_v * car_s[NS].dy;
			car_s[MUL_ST] <= car_s[NS];
		end
	end

	// Sum stage: combine products, round to Q16.16
	logic signed [SUM_W-1:0] px_full;
	logic signed [SUM_W-1:0] py_full;

	always_comb begin
		px_full = $signed({cdx_s[PROD_W-1], cdx_s}) - $signed({sdy_s[PROD_W-1], sdy_s})
			+ ROUND_HALF;
		py_full = $signed({sdx_s[PROD_W-1], sdx_s}) + $signed({cdy_s[PROD_W-1], cdy_s})
			+ ROUND_HALF;
	end

	always_ff @(posedge clk) begin
		if (rdy[SUM_ST]) begin
			px_sh_s <= px_full[SUM_W-1:30];
			py_sh_s <= py_full[SUM_W-1:30];
			rx_s    <= car_s[MUL_ST].rx;
			ry_s    <= car_s[MUL_ST].ry;
			hd_s    <= car_s[MUL_ST].heading;
		end
	end

	// Output stage: add reference position and saturate
	logic signed [SH_W:0] px_pos;
	logic signed [SH_W:0] py_pos;
	pose_out_t            out_nxt;

	always_comb begin
		px_pos = $signed({px_sh_s[SH_W-1], px_sh_s}) + $signed({{(SH_W-31){rx_s[31]}}, rx_s});
		py_pos = $signed({py_sh_s[SH_W-1], py_sh_s}) + $signed({{(SH_W-31){ry_s[31]}}, ry_s});
		if (px_pos > $signed(38'sd2147483647)) begin
			out_nxt.pose_x = 32'sh7FFFFFFF;
		end else if (px_pos < $signed(-38'sd2147483648)) begin
			out_nxt.pose_x = 32'sh80000000;
		end else begin
			out_nxt.pose_x = px_pos[31:0];
		end
		if (py_pos > $signed(38'sd2147483647)) begin
			out_nxt.pose_y = 32'sh7FFFFFFF;
		end else if (py_pos < $signed(-38'sd2147483648)) begin
			out_nxt.pose_y = 32'sh80000000;
		end else begin
			out_nxt.pose_y = py_pos[31:0];
		end
		out_nxt.pose_heading = hd_s;
	end

	always_ff @(posedge clk) begin
		if (rdy[OUT_ST]) begin
			out_s <= out_nxt;
		end
	end

	assign out_valid = v_s[OUT_ST];
	assign out_data  = out_s;

endmodule

### sv/ppc_checker.sv
// ----------------------------------------------------------------------------
// ppc_checker: port-level checks for the planar pose compose unit
// Watches the handshakes, output heading range and reset state; bound to the top level.
// ----------------------------------------------------------------------------
module ppc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input ppc_pkg::pose_in_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input ppc_pkg::pose_out_t out_data
);
	import ppc_pkg::*;

	// Offered input word holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input word changed while waiting");

	// Stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// A draining output never blocks the input side
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	// Composed heading always lies within one turn around zero
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.pose_heading <= PI_HEAD)
			&& (out_data.pose_heading >= -PI_HEAD))
		else $error("output heading outside -pi..pi");

	// Pipeline comes out of reset empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind planar_pose_compose_unit ppc_checker u_ppc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
